[hw/rtl/rational_add_reduce_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the rational add/reduce core
// Concurrent assertion wrappers; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ADD_REDUCE_CORE_MACROS_SVH
`define RATIONAL_ADD_REDUCE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked check, switched off while reset is high
`define RAR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds through reset
`define RAR_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAR_ASSERT(name, clk, rst, prop, msg)
`define RAR_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[hw/rtl/rar_pkg.sv]
// ----------------------------------------------------------------------------
// rar_pkg
// Shared constants, datapath commands and status for the rational add/reduce
// core.
// ----------------------------------------------------------------------------
package rar_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int NUM_OUT_W         = 33;
   localparam int DEN_OUT_W         = 31;

   // one command per cycle from the controller to the datapath
   typedef enum logic [3:0] {
      CMD_NONE     = 4'd0,
      CMD_CAPTURE  = 4'd1,
      CMD_MUL_P1   = 4'd2,
      CMD_MUL_P2   = 4'd3,
      CMD_MUL_DEN  = 4'd4,
      CMD_SUM      = 4'd5,
      CMD_ABS      = 4'd6,
      CMD_PASS_A   = 4'd7,
      CMD_GCD_STEP = 4'd8,
      CMD_DIV_INIT = 4'd9,
      CMD_DIV_STEP = 4'd10,
      CMD_OUT_LOAD = 4'd11
   } cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic div_last;
   } dp_stat_type;

endpackage

[hw/rtl/rar_ctrl.sv]
// ----------------------------------------------------------------------------
// rar_ctrl
// Sequencer: steps the datapath through multiply, sum, binary GCD and the
// two-lane division, and owns both handshakes.
// ----------------------------------------------------------------------------
module rar_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rar_pkg::dp_stat_type stat,
   output rar_pkg::cmd_type     cmd
);
   import rar_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_MUL_P1  = 10'b00_0000_0010,
      ST_MUL_P2  = 10'b00_0000_0100,
      ST_MUL_DEN = 10'b00_0000_1000,
      ST_SUM     = 10'b00_0001_0000,
      ST_ABS     = 10'b00_0010_0000,
      ST_PASS_A  = 10'b00_0100_0000,
      ST_GCD_RUN = 10'b00_1000_0000,
      ST_DIV_RUN = 10'b01_0000_0000,
      ST_OUT     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_CAPTURE;
               state_in = req_action ? ST_MUL_P1 : ST_PASS_A;
            end
         end
         ST_MUL_P1: begin
            cmd      = CMD_MUL_P1;
            state_in = ST_MUL_P2;
         end
         ST_MUL_P2: begin
            cmd      = CMD_MUL_P2;
            state_in = ST_MUL_DEN;
         end
         ST_MUL_DEN: begin
            cmd      = CMD_MUL_DEN;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd      = CMD_SUM;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            cmd      = CMD_ABS;
            state_in = ST_GCD_RUN;
         end
         ST_PASS_A: begin
            cmd      = CMD_PASS_A;
            state_in = ST_GCD_RUN;
         end
         ST_GCD_RUN: begin
            if (stat.gcd_done) begin
               cmd      = CMD_DIV_INIT;
               state_in = ST_DIV_RUN;
            end else begin
               cmd = CMD_GCD_STEP;
            end
         end
         ST_DIV_RUN: begin
            cmd = CMD_DIV_STEP;
            if (stat.div_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the output register to drain
            if (out_free) begin
               cmd      = CMD_OUT_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd == CMD_OUT_LOAD) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/rar_dp.sv]
// ----------------------------------------------------------------------------
// rar_dp
// Datapath: operand magnitudes, one shared multiplier, signed sum, binary GCD
// unit, two-lane restoring divider and the output register.
// ----------------------------------------------------------------------------
module rar_dp #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                clock,
   input  rar_pkg::cmd_type                    cmd,
   input  logic                                req_action,
   input  logic signed [OPERAND_WIDTH-1:0]     req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]     req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]     req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]     req_b_den,
   output rar_pkg::dp_stat_type                stat,
   output logic signed [rar_pkg::NUM_OUT_W-1:0] rsp_res_num,
   output logic [rar_pkg::DEN_OUT_W-1:0]       rsp_res_den,
   output logic                                rsp_zero_den_fixed
);
   import rar_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int MW = 2 * OPERAND_WIDTH;
   localparam int CW = $clog2(MW);
   localparam int XN = (MW > NUM_OUT_W) ? MW : NUM_OUT_W;
   localparam int XD = (MW > DEN_OUT_W) ? MW : DEN_OUT_W;

   // operand magnitudes and signs
   logic [W-1:0]  an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic          an_neg_ff, an_neg_in, ad_neg_ff, ad_neg_in;
   logic          bn_neg_ff, bn_neg_in, bd_neg_ff, bd_neg_in;
   logic          fixed_ff, fixed_in;
   // products and sum
   logic [MW-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic          p1_neg_ff, p1_neg_in, p2_neg_ff, p2_neg_in;
   logic [MW:0]   sum_ff, sum_in;
   logic          num_neg_ff, num_neg_in, den_neg_ff, den_neg_in;
   // GCD operands, dividends (later quotients), remainders
   logic [MW-1:0] u_ff, u_in, v_ff, v_in, nq_ff, nq_in, dq_ff, dq_in;
   logic [MW-1:0] rn_ff, rn_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   // output register
   logic signed [NUM_OUT_W-1:0] res_num_ff, res_num_in;
   logic [DEN_OUT_W-1:0]        res_den_ff, res_den_in;
   logic                        res_fixed_ff, res_fixed_in;

   logic [W-1:0]  an_abs, ad_abs, bn_abs, bd_abs;
   logic          ad_zero, bd_zero;
   logic [W-1:0]  mul_a, mul_b;
   logic [MW-1:0] prod;
   logic [MW:0]   u_m_v, v_m_u;
   logic [MW:0]   r_n, r_d, v_ext;
   logic          ge_n, ge_d;
   logic          out_neg;
   logic [XN-1:0] num_x, num_v;
   logic [XD-1:0] den_x;

   assign an_abs  = req_a_num[W-1] ? W'(-req_a_num) : W'(req_a_num);
   assign ad_abs  = req_a_den[W-1] ? W'(-req_a_den) : W'(req_a_den);
   assign bn_abs  = req_b_num[W-1] ? W'(-req_b_num) : W'(req_b_num);
   assign bd_abs  = req_b_den[W-1] ? W'(-req_b_den) : W'(req_b_den);
   assign ad_zero = (ad_abs == '0);
   assign bd_zero = (bd_abs == '0);

   // shared W x W multiplier
   assign mul_a = (cmd == CMD_MUL_P1) ? an_ff : ad_ff;
   assign mul_b = (cmd == CMD_MUL_P2) ? bn_ff : bd_ff;
   assign prod  = MW'(mul_a) * MW'(mul_b);

   assign u_m_v = {1'b0, u_ff} - {1'b0, v_ff};
   assign v_m_u = {1'b0, v_ff} - {1'b0, u_ff};

   // one restoring step per lane, shared divisor
   assign v_ext = {1'b0, v_ff};
   assign r_n   = {rn_ff, nq_ff[MW-1]};
   assign r_d   = {rd_ff, dq_ff[MW-1]};
   assign ge_n  = (r_n >= v_ext);
   assign ge_d  = (r_d >= v_ext);

   assign out_neg = (nq_ff != '0) && (num_neg_ff ^ den_neg_ff);
   assign num_x   = XN'(nq_ff);
   assign num_v   = out_neg ? (~num_x + XN'(1)) : num_x;
   assign den_x   = XD'(dq_ff);

   always_comb begin
      an_in = an_ff;  an_neg_in = an_neg_ff;
      ad_in = ad_ff;  ad_neg_in = ad_neg_ff;
      bn_in = bn_ff;  bn_neg_in = bn_neg_ff;
      bd_in = bd_ff;  bd_neg_in = bd_neg_ff;
      fixed_in   = fixed_ff;
      p1_in      = p1_ff;  p1_neg_in = p1_neg_ff;
      p2_in      = p2_ff;  p2_neg_in = p2_neg_ff;
      sum_in     = sum_ff;
      num_neg_in = num_neg_ff;
      den_neg_in = den_neg_ff;
      u_in  = u_ff;  v_in  = v_ff;
      nq_in = nq_ff; dq_in = dq_ff;
      rn_in = rn_ff; rd_in = rd_ff;
      cnt_in       = cnt_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      res_fixed_in = res_fixed_ff;
      case (cmd)
         CMD_CAPTURE: begin
            an_in     = an_abs;
            an_neg_in = req_a_num[W-1];
            ad_in     = ad_zero ? W'(1) : ad_abs;
            ad_neg_in = req_a_den[W-1];
            bn_in     = bn_abs;
            bn_neg_in = req_b_num[W-1];
            bd_in     = bd_zero ? W'(1) : bd_abs;
            bd_neg_in = req_b_den[W-1];
            // b's denominator only counts when adding
            fixed_in  = ad_zero | (req_action & bd_zero);
         end
         CMD_MUL_P1: begin
            p1_in     = prod;
            p1_neg_in = an_neg_ff ^ bd_neg_ff;
         end
         CMD_MUL_P2: begin
            p2_in     = prod;
            p2_neg_in = ad_neg_ff ^ bn_neg_ff;
         end
         CMD_MUL_DEN: begin
            v_in       = prod;
            dq_in      = prod;
            den_neg_in = ad_neg_ff ^ bd_neg_ff;
         end
         CMD_SUM: begin
            if (p1_neg_ff == p2_neg_ff) begin
               sum_in = {1'b0, p1_ff} + {1'b0, p2_ff};
            end else begin
               sum_in = {1'b0, p1_ff} - {1'b0, p2_ff};
            end
         end
         CMD_ABS: begin
            if (p1_neg_ff != p2_neg_ff && sum_ff[MW]) begin
               // p2 dominates: magnitude is the negated difference
               u_in       = MW'(~sum_ff + (MW+1)'(1));
               num_neg_in = p2_neg_ff;
            end else begin
               u_in       = sum_ff[MW-1:0];
               num_neg_in = p1_neg_ff;
            end
            nq_in = u_in;
         end
         CMD_PASS_A: begin
            u_in       = MW'(an_ff);
            nq_in      = MW'(an_ff);
            v_in       = MW'(ad_ff);
            dq_in      = MW'(ad_ff);
            num_neg_in = an_neg_ff;
            den_neg_in = ad_neg_ff;
         end
         CMD_GCD_STEP: begin
            if (!u_ff[0] && !v_ff[0]) begin
               // common factor of two: strip it from the dividends as well
               u_in  = u_ff >> 1;
               v_in  = v_ff >> 1;
               nq_in = nq_ff >> 1;
               dq_in = dq_ff >> 1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!u_m_v[MW]) begin
               u_in = u_m_v[MW:1];
            end else begin
               v_in = v_m_u[MW:1];
            end
         end
         CMD_DIV_INIT: begin
            rn_in  = '0;
            rd_in  = '0;
            cnt_in = CW'(MW - 1);
         end
         CMD_DIV_STEP: begin
            rn_in  = ge_n ? MW'(r_n - v_ext) : r_n[MW-1:0];
            rd_in  = ge_d ? MW'(r_d - v_ext) : r_d[MW-1:0];
            nq_in  = {nq_ff[MW-2:0], ge_n};
            dq_in  = {dq_ff[MW-2:0], ge_d};
            cnt_in = cnt_ff - CW'(1);
         end
         CMD_OUT_LOAD: begin
            res_num_in   = num_v[NUM_OUT_W-1:0];
            res_den_in   = den_x[DEN_OUT_W-1:0];
            res_fixed_in = fixed_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      an_ff <= an_in;  an_neg_ff <= an_neg_in;
      ad_ff <= ad_in;  ad_neg_ff <= ad_neg_in;
      bn_ff <= bn_in;  bn_neg_ff <= bn_neg_in;
      bd_ff <= bd_in;  bd_neg_ff <= bd_neg_in;
      fixed_ff   <= fixed_in;
      p1_ff      <= p1_in;  p1_neg_ff <= p1_neg_in;
      p2_ff      <= p2_in;  p2_neg_ff <= p2_neg_in;
      sum_ff     <= sum_in;
      num_neg_ff <= num_neg_in;
      den_neg_ff <= den_neg_in;
      u_ff  <= u_in;  v_ff  <= v_in;
      nq_ff <= nq_in; dq_ff <= dq_in;
      rn_ff <= rn_in; rd_ff <= rd_in;
      cnt_ff       <= cnt_in;
      res_num_ff   <= res_num_in;
      res_den_ff   <= res_den_in;
      res_fixed_ff <= res_fixed_in;
   end

   assign stat.gcd_done = (u_ff == '0);
   assign stat.div_last = (cnt_ff == '0);

   assign rsp_res_num        = res_num_ff;
   assign rsp_res_den        = res_den_ff;
   assign rsp_zero_den_fixed = res_fixed_ff;

endmodule

[hw/rtl/rational_add_reduce_core.sv]
// ----------------------------------------------------------------------------
// rational_add_reduce_core
// Reduces a signed fraction, or adds two and reduces the sum, by binary GCD
// and a two-lane restoring divider.
// ----------------------------------------------------------------------------
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   action, a_num, a_den, b_num, b_den
//   rsp      out  rsp_valid/rsp_ready   res_num, res_den, zero_den_fixed
//
// One item at a time, M = 2*OPERAND_WIDTH. Steps per item: capture, setup
// (MUL_P1, MUL_P2, MUL_DEN, SUM, ABS when adding; PASS_A when reducing), the
// GCD loop (its last step starts the divider), M division steps and the
// output load. Besides the mode, only the GCD loop varies from item to item.
// Reset: synchronous, clears the sequencer and rsp_valid only.
// A result waiting in the output register does not block the next item;
// only its final load waits for the register to drain.
// ----------------------------------------------------------------------------
`include "rational_add_reduce_core_macros.svh"

module rational_add_reduce_core #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic signed [OPERAND_WIDTH-1:0]      req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]      req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]      req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]      req_b_den,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rar_pkg::NUM_OUT_W-1:0] rsp_res_num,
   output logic [rar_pkg::DEN_OUT_W-1:0]        rsp_res_den,
   output logic                                 rsp_zero_den_fixed
);
   import rar_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;

   rar_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rar_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .req_action         (req_action),
      .req_a_num          (req_a_num),
      .req_a_den          (req_a_den),
      .req_b_num          (req_b_num),
      .req_b_den          (req_b_den),
      .stat               (stat),
      .rsp_res_num        (rsp_res_num),
      .rsp_res_den        (rsp_res_den),
      .rsp_zero_den_fixed (rsp_zero_den_fixed)
   );

   // a beat taken on req means the sequencer is busy next cycle
   `RAR_ASSERT(a_busy_after_accept, clock, reset,
      req_valid && req_ready |=> !req_ready, "req_ready stayed high after an accepted beat")
   // never overwrite a result that has not been taken
   `RAR_ASSERT(a_no_overwrite, clock, reset,
      cmd == CMD_OUT_LOAD |-> !rsp_valid || rsp_ready, "output register loaded over a pending beat")
   // a zero numerator always comes out as 0/1
   `RAR_ASSERT(a_zero_is_unit, clock, reset,
      rsp_valid && rsp_res_num == '0 |-> rsp_res_den == DEN_OUT_W'(1),
      "zero result with denominator other than one")

endmodule
